// File: hdl/xml_entity_decoder_macros.svh
`ifndef XML_ENTITY_DECODER_MACROS_SVH
`define XML_ENTITY_DECODER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define XED_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define XED_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/xed_pkg.sv
`default_nettype none

package xed_pkg;

  localparam int ENT_NUM      = 5;
  localparam int ENT_BODY_MAX = 5;
  localparam int MAX_CHARS    = 6;
  localparam int CMD_DEPTH_DEF = 4;

  localparam logic [7:0]  AMP_CHAR     = 8'h26;
  localparam logic [7:0]  NUL_CHAR     = 8'h00;
  localparam logic [15:0] LIMIT_RESET  = 16'd255;

  // entity bodies after the ampersand: lt; gt; amp; quot; apos;
  localparam logic [7:0] ENT_BODY [ENT_NUM][ENT_BODY_MAX] = '{
    '{8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},
    '{8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},
    '{8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},
    '{8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},
    '{8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b}
  };
  localparam logic [2:0] ENT_LEN [ENT_NUM] = '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5};
  localparam logic [7:0] ENT_CHAR [ENT_NUM] = '{8'h3c, 8'h3e, 8'h26, 8'h22, 8'h27};

  // work for the back end: up to six characters, then an optional terminator
  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [2:0]                count;
    logic                      term;
  } cmd_t;

endpackage

`default_nettype wire

// File: hdl/xed_front.sv
`default_nettype none

module xed_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          cmd_push,
  output xed_pkg::cmd_t cmd
);
  import xed_pkg::*;

  logic               amp_pending, amp_pending_next;
  logic [2:0]         prefix_count, prefix_count_next;
  logic [ENT_NUM-1:0] alive, alive_next;
  logic [3:0][7:0]    prefix_buffer;
  logic               string_ended, string_ended_next;
  logic               buf_we;
  logic [ENT_NUM-1:0] hit_full, hit_live;
  logic [7:0]         full_char;
  cmd_t               c;

  function automatic cmd_t append_char(cmd_t cin, logic [7:0] ch);
    cmd_t r;
    r = cin;
    r.chars[r.count] = ch;
    r.count = r.count + 3'd1;
    return r;
  endfunction

  // ampersand and held bytes, literally
  function automatic cmd_t add_flush(cmd_t cin, logic [3:0][7:0] pb, logic [2:0] cnt);
    cmd_t r;
    r = append_char(cin, AMP_CHAR);
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < cnt) r = append_char(r, pb[i]);
    end
    return r;
  endfunction

  always_comb begin
    hit_full  = '0;
    hit_live  = '0;
    full_char = NUL_CHAR;
    for (int k = 0; k < ENT_NUM; k++) begin
      if (alive[k] && prefix_count < ENT_LEN[k] &&
          ENT_BODY[k][prefix_count] == in_byte) begin
        if (prefix_count + 3'd1 == ENT_LEN[k]) begin
          hit_full[k] = 1'b1;
          full_char   = ENT_CHAR[k];
        end else begin
          hit_live[k] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic            plain;
    logic [3:0][7:0] view;
    plain              = 1'b0;
    view               = prefix_buffer;
    c                  = '0;
    amp_pending_next   = amp_pending;
    prefix_count_next  = prefix_count;
    alive_next         = alive;
    string_ended_next  = string_ended;
    buf_we             = 1'b0;
    if (string_ended) begin
      // drop bytes up to and including the last-flagged byte
      if (in_last) string_ended_next = 1'b0;
    end else if (in_byte == NUL_CHAR) begin
      if (amp_pending) c = add_flush(c, view, prefix_count);
      amp_pending_next  = 1'b0;
      prefix_count_next = '0;
      c.term            = 1'b1;
      string_ended_next = !in_last;
    end else begin
      if (amp_pending) begin
        if (|hit_full) begin
          c = append_char(c, full_char);
          amp_pending_next  = 1'b0;
          prefix_count_next = '0;
        end else if ((|hit_live) && prefix_count < 3'd4) begin
          buf_we                    = 1'b1;
          view[prefix_count[1:0]]   = in_byte;
          prefix_count_next         = prefix_count + 3'd1;
          alive_next                = hit_live;
        end else begin
          // broken entity: release it, then treat the byte as fresh
          c = add_flush(c, view, prefix_count);
          amp_pending_next  = 1'b0;
          prefix_count_next = '0;
          plain             = 1'b1;
        end
      end else begin
        plain = 1'b1;
      end
      if (plain) begin
        if (in_byte == AMP_CHAR) begin
          amp_pending_next  = 1'b1;
          prefix_count_next = '0;
          alive_next        = '1;
        end else begin
          c = append_char(c, in_byte);
        end
      end
      if (in_last) begin
        if (amp_pending_next) c = add_flush(c, view, prefix_count_next);
        amp_pending_next  = 1'b0;
        prefix_count_next = '0;
        c.term            = 1'b1;
      end
    end
  end

  assign cmd      = c;
  assign cmd_push = accept && !string_ended && (c.count != 3'd0 || c.term);

  always_ff @(posedge clk) begin
    if (rst) begin
      amp_pending  <= 1'b0;
      prefix_count <= '0;
      alive        <= '0;
      string_ended <= 1'b0;
    end else if (accept) begin
      amp_pending  <= amp_pending_next;
      prefix_count <= prefix_count_next;
      alive        <= alive_next;
      string_ended <= string_ended_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && buf_we) prefix_buffer[prefix_count[1:0]] <= in_byte;
  end

endmodule

`default_nettype wire

// File: hdl/xed_cmd_fifo.sv
`default_nettype none

module xed_cmd_fifo #(
  parameter int DEPTH = xed_pkg::CMD_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  xed_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output xed_pkg::cmd_t rd_data,
  output logic          not_empty
);
  import xed_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_wr, do_rd;

  assign full      = (fill == CNT_W'(DEPTH));
  assign not_empty = (fill != '0);
  assign rd_data   = slots[rd_ptr];
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

endmodule

`default_nettype wire

// File: hdl/xed_back.sv
`default_nettype none

module xed_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [15:0]   cfg_wr_data,
  input  logic          cmd_valid,
  input  xed_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic          out_last,
  output logic          truncated
);
  import xed_pkg::*;

  logic [15:0] char_limit;
  logic [15:0] emitted_count;
  logic        overflow_seen;
  logic [2:0]  idx;
  logic        out_valid;
  logic        is_char, fits, space, step, emit, last_elem;
  logic [7:0]  cur_char;

  always_comb begin
    cur_char = NUL_CHAR;
    for (int i = 0; i < MAX_CHARS; i++) begin
      if (idx == 3'(i)) cur_char = cmd.chars[i];
    end
  end

  assign is_char   = idx < cmd.count;
  assign fits      = emitted_count < char_limit;
  assign space     = !out_valid || pop;
  // a dropped character needs no output slot
  assign step      = cmd_valid && (is_char ? (!fits || space) : space);
  assign emit      = step && (!is_char || fits);
  assign last_elem = cmd.term ? (idx == cmd.count) : (idx + 3'd1 == cmd.count);
  assign cmd_pop   = step && last_elem;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_limit    <= LIMIT_RESET;
      emitted_count <= '0;
      overflow_seen <= 1'b0;
      idx           <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) char_limit <= (cfg_wr_data == 16'd0) ? 16'd0 : cfg_wr_data - 16'd1;
      if (step) begin
        idx <= cmd_pop ? 3'd0 : idx + 3'd1;
        if (is_char) begin
          if (fits) emitted_count <= emitted_count + 16'd1;
          else      overflow_seen <= 1'b1;
        end else begin
          emitted_count <= '0;
          overflow_seen <= 1'b0;
        end
      end
      if (emit)     out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte  <= is_char ? cur_char : NUL_CHAR;
      out_last  <= !is_char;
      truncated <= overflow_seen;
    end
  end

endmodule

`default_nettype wire

// File: hdl/xml_entity_decoder.sv
// an item's first result passes the command queue and then the output register
// throughput: one input per cycle while pop is high and each yields at most one result
// the back end handles an input's results (and dropped characters) one at a time
// a four-entry command queue between front and back absorbs flush bursts
// reset: synchronous, clears all pending state and queues, char_limit returns to 255
`default_nettype none

module xml_entity_decoder #(
  parameter int CMD_DEPTH = xed_pkg::CMD_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        truncated,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import xed_pkg::*;

  logic accept;
  logic cmd_push, cmd_pop, cmd_valid;
  cmd_t cmd_in, cmd_out;

  assign accept = push && !full;

  xed_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  xed_cmd_fifo #(.DEPTH(CMD_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cmd_push),
    .wr_data   (cmd_in),
    .full      (full),
    .rd_en     (cmd_pop),
    .rd_data   (cmd_out),
    .not_empty (cmd_valid)
  );

  xed_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd_out),
    .cmd_pop     (cmd_pop),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .truncated   (truncated)
  );

endmodule

`default_nettype wire

// File: hdl/xed_checker.sv
`default_nettype none
`include "xml_entity_decoder_macros.svh"

module xed_checker (
  input wire        clk,
  input wire        rst,
  input wire        full,
  input wire        empty,
  input wire        pop,
  input wire [7:0]  out_byte,
  input wire        out_last,
  input wire        truncated
);

  // a zero byte only ever appears as the terminator
  `XED_ASSERT_IMP(a_term_zero, !empty, (out_byte == 8'h00) == out_last, "zero byte and last flag disagree")

  // nothing is left over once reset is released
  `XED_ASSERT_IMP(a_reset_clear, $past(rst), empty && !full, "queues not clear after reset")

  // a stalled result holds
  `XED_ASSERT_NXT(a_out_hold, !empty && !pop, !empty && $stable(out_byte) && $stable(out_last) && $stable(truncated), "result changed while stalled")

endmodule

bind xml_entity_decoder xed_checker u_chk (.*);

`default_nettype wire
